// File: rtl/core/ibbf_pkg.sv
`default_nettype none

package ibbf_pkg;

  // Bound width (Q2.14 by default) and child numbering
  localparam int BW            = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int NUM_CHILD     = 8;
  localparam int IDX_W         = 3;
  localparam logic [IDX_W-1:0] CHILD_LAST = IDX_W'(NUM_CHILD - 1);

  // One input box
  typedef struct packed {
    logic signed [BW-1:0] mu1_low;
    logic signed [BW-1:0] mu1_high;
    logic signed [BW-1:0] mu2_low;
    logic signed [BW-1:0] mu2_high;
    logic signed [BW-1:0] rho_low;
    logic signed [BW-1:0] rho_high;
  } box_t;

  // One interval with its split point
  typedef struct packed {
    logic signed [BW-1:0] lo;
    logic signed [BW-1:0] mid;
    logic signed [BW-1:0] hi;
  } ivl_t;

  // Box held while its children go out
  typedef struct packed {
    logic  valid;
    logic [IDX_W-1:0] idx;
    ivl_t  mu1;
    ivl_t  mu2;
    ivl_t  rho;
  } cur_t;

  // One child result
  typedef struct packed {
    logic signed [BW-1:0] child_mu1_low;
    logic signed [BW-1:0] child_mu1_high;
    logic signed [BW-1:0] child_mu2_low;
    logic signed [BW-1:0] child_mu2_high;
    logic signed [BW-1:0] child_rho_low;
    logic signed [BW-1:0] child_rho_high;
    logic                 kept;
    logic [IDX_W-1:0]     child_index;
    logic                 last;
  } child_t;

endpackage

`default_nettype wire

// File: rtl/core/ibbf_box_if.sv
`default_nettype none

interface ibbf_box_if import ibbf_pkg::*; ();
  logic valid;
  logic ready;
  box_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ibbf_child_if.sv
`default_nettype none

interface ibbf_child_if import ibbf_pkg::*; ();
  logic   valid;
  logic   ready;
  child_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ibbf_seq.sv
`default_nettype none

module ibbf_seq import ibbf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  ibbf_box_if.sink   box,
  input  wire logic  adv,
  output cur_t       cur
);

  logic              busy;
  logic [IDX_W-1:0]  idx;
  ivl_t              mu1;
  ivl_t              mu2;
  ivl_t              rho;
  logic              take;
  logic signed [BW:0] sum1;
  logic signed [BW:0] sum2;
  logic signed [BW:0] sum3;

  // Next box may enter as the last child of the current one leaves
  assign box.ready = !busy || (adv && (idx == CHILD_LAST));
  assign take      = box.valid && box.ready;

  // Floor midpoints: arithmetic shift of the exact 17-bit sum
  assign sum1 = (BW+1)'(box.data.mu1_low) + (BW+1)'(box.data.mu1_high);
  assign sum2 = (BW+1)'(box.data.mu2_low) + (BW+1)'(box.data.mu2_high);
  assign sum3 = (BW+1)'(box.data.rho_low) + (BW+1)'(box.data.rho_high);

  // Child counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (adv) begin
      if (idx == CHILD_LAST) begin
        busy <= 1'b0;
      end
      idx <= idx + 1'b1;
    end
  end

  // Box register
  always_ff @(posedge clk) begin
    if (take) begin
      mu1 <= '{lo: box.data.mu1_low, mid: sum1[BW:1], hi: box.data.mu1_high};
      mu2 <= '{lo: box.data.mu2_low, mid: sum2[BW:1], hi: box.data.mu2_high};
      rho <= '{lo: box.data.rho_low, mid: sum3[BW:1], hi: box.data.rho_high};
    end
  end

  assign cur = '{valid: busy, idx: idx, mu1: mu1, mu2: mu2, rho: rho};

endmodule

`default_nettype wire

// File: rtl/core/ibbf_sel.sv
`default_nettype none

module ibbf_sel import ibbf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire cur_t cur,
  output child_t    child
);

  // Room for a three-term sum and for 1.0 itself
  localparam int CW = (FRAC_BITS + 2 > BW + 2) ? FRAC_BITS + 2 : BW + 2;
  localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  logic signed [BW-1:0] m1l, m1h, m2l, m2h, rl, rh;
  logic signed [CW-1:0] e1l, e1h, e2l, e2h, erl, erh;
  logic signed [CW-1:0] s0, s1, s2, s3;
  logic                 canon;
  logic                 rows_ok;

  // Pick halves: index bit set selects the upper half
  assign m1l = cur.idx[2] ? cur.mu1.mid : cur.mu1.lo;
  assign m1h = cur.idx[2] ? cur.mu1.hi  : cur.mu1.mid;
  assign m2l = cur.idx[1] ? cur.mu2.mid : cur.mu2.lo;
  assign m2h = cur.idx[1] ? cur.mu2.hi  : cur.mu2.mid;
  assign rl  = cur.idx[0] ? cur.rho.mid : cur.rho.lo;
  assign rh  = cur.idx[0] ? cur.rho.hi  : cur.rho.mid;

  // Sign-extend to the compare width
  assign e1l = CW'(m1l);
  assign e1h = CW'(m1h);
  assign e2l = CW'(m2l);
  assign e2h = CW'(m2h);
  assign erl = CW'(rl);
  assign erh = CW'(rh);

  // Canonical ordering of the two means
  assign canon = (e1h >= e2l) && (e1h >= CW'(0)) && ((-e2h) <= e1h);

  // Lower bounds of the four signed triangle sums
  assign s0 = -e1h - e2h - erh;
  assign s1 = -e1h + e2l + erl;
  assign s2 = e1l - e2h + erl;
  assign s3 = e1l + e2l - erh;
  assign rows_ok = (s0 <= ONE) && (s1 <= ONE) && (s2 <= ONE) && (s3 <= ONE);

  assign child = '{
    child_mu1_low:  m1l,
    child_mu1_high: m1h,
    child_mu2_low:  m2l,
    child_mu2_high: m2h,
    child_rho_low:  rl,
    child_rho_high: rh,
    kept:           canon && rows_ok,
    child_index:    cur.idx,
    last:           cur.idx == CHILD_LAST
  };

endmodule

`default_nettype wire

// File: rtl/core/interval_box_bisect_filter.sv
// Interval box bisect filter.
// The box channel (valid/ready) takes one box of three intervals: mu1, mu2
// and rho, each a pair of signed Q2.14 bounds. Every interval is split at the
// floor of its midpoint, and the eight child boxes leave on the child channel
// in index order (bit 2 mu1 half, bit 1 mu2 half, bit 0 rho half), each with
// a kept flag for the canonical and triangle-inequality tests, and with last
// set on child 7.
// The first child of a box passes the box register, then the output
// register. Throughput: one child per cycle while the receiver holds ready
// high, paced by the child counter; the next box is taken in the same cycle
// as the last child of the current box enters the output register.
// Reset (synchronous, rst high) drops any box in flight and empties the output
// register. When the receiver holds ready low, the output register keeps its
// child, the counter stops and the box channel stays not ready after the
// held box; nothing is lost or repeated.

`default_nettype none

module interval_box_bisect_filter import ibbf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ibbf_box_if.sink    box,
  ibbf_child_if.source child
);

  cur_t   cur;
  child_t sel_child;
  logic   load;
  logic   out_valid;
  child_t out_data;

  // Output register loads when empty or being drained
  assign load = cur.valid && (!out_valid || child.ready);

  ibbf_seq u_seq (
    .clk (clk),
    .rst (rst),
    .box (box),
    .adv (load),
    .cur (cur)
  );

  ibbf_sel #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sel (
    .cur   (cur),
    .child (sel_child)
  );

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (child.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= sel_child;
    end
  end

  assign child.valid = out_valid;
  assign child.data  = out_data;

endmodule

`default_nettype wire
